@@ rtl/ycbcr_colorimetry_matrix_defines.svh @@
// assertion helpers shared by the rtl
`ifndef YCBCR_COLORIMETRY_MATRIX_DEFINES_SVH
`define YCBCR_COLORIMETRY_MATRIX_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define YCM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define YCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ycm_pkg.sv @@
package ycm_pkg;

  localparam int unsigned PixW   = 8;
  localparam int unsigned CoefW  = 8;
  localparam int unsigned SumW   = 18;
  localparam int unsigned FracW  = 6;
  localparam int unsigned LumaOfs   = 16;
  localparam int unsigned ChromaOfs = 128;
  localparam int unsigned PixMax    = 255;

  typedef enum logic [1:0] {
    MODE_709_TO_601 = 2'd0,
    MODE_601_TO_709 = 2'd1,
    MODE_IDENTITY   = 2'd2,
    MODE_SPARE      = 2'd3
  } mode_e;

  typedef struct packed {
    logic [PixW-1:0] luma_first;
    logic [PixW-1:0] chroma_blue;
    logic [PixW-1:0] luma_second;
    logic [PixW-1:0] chroma_red;
  } ycm_req_t;

  typedef struct packed {
    logic [PixW-1:0] new_luma_first;
    logic [PixW-1:0] new_chroma_blue;
    logic [PixW-1:0] new_luma_second;
    logic [PixW-1:0] new_chroma_red;
  } ycm_rsp_t;

  typedef struct packed {
    logic signed [CoefW-1:0] kyb;
    logic signed [CoefW-1:0] kyr;
    logic signed [CoefW-1:0] kbb;
    logic signed [CoefW-1:0] kbr;
    logic signed [CoefW-1:0] krb;
    logic signed [CoefW-1:0] krr;
  } coef_t;

  // matrix rows in units of 1/64; spare code acts as identity
  function automatic coef_t coef_lookup(mode_e mode);
    coef_t c;
    unique case (mode)
      MODE_709_TO_601: c = '{kyb: 8'sd6,  kyr: 8'sd12,  kbb: 8'sd63,
                             kbr: -8'sd7, krb: -8'sd5,  krr: 8'sd62};
      MODE_601_TO_709: c = '{kyb: -8'sd7, kyr: -8'sd13, kbb: 8'sd65,
                             kbr: 8'sd7,  krb: 8'sd5,   krr: 8'sd66};
      default:         c = '{kyb: 8'sd0,  kyr: 8'sd0,   kbb: 8'sd64,
                             kbr: 8'sd0,  krb: 8'sd0,   krr: 8'sd64};
    endcase
    return c;
  endfunction

endpackage

@@ rtl/ycbcr_colorimetry_matrix.sv @@
// Converts one 4:2:2 macropixel (Y0, Cb, Y1, Cr) per clock through a 3x3 matrix in 1/64 steps
// selected by the mode register (0 BT.709 to BT.601, 1 BT.601 to BT.709, 2 or 3 identity).
// A request is captured in an input register, the matrix products and clamping sit between
// that register and the result register, and one request is taken every clock while the
// result side keeps up. Mode is written through the config channel, which is always ready;
// write it only while no request is in flight.
`include "ycbcr_colorimetry_matrix_defines.svh"

module ycbcr_colorimetry_matrix
  import ycm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  ycm_req_t    in_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output ycm_rsp_t    out_rsp_o
);

  mode_e    mode_q;
  logic     s1_valid_q;
  ycm_req_t s1_req_q;
  logic     out_valid_q;
  ycm_rsp_t out_rsp_q;
  ycm_rsp_t out_rsp_d;

  logic out_free;
  logic s1_adv;
  coef_t coef;

  logic signed [SumW-1:0] cbd, crd;
  logic signed [SumW-1:0] sum_y0, sum_y1, sum_cb, sum_cr, cross_y;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign s1_adv      = s1_valid_q && out_free;
  assign in_ready_o  = !s1_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_709_TO_601;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= mode_e'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_req_q <= in_req_i;
    end
    if (s1_adv) begin
      out_rsp_q <= out_rsp_d;
    end
  end

  function automatic logic signed [SumW-1:0] luma_base(logic [PixW-1:0] y);
    logic [PixW-1:0] yo;
    yo = (y > PixW'(LumaOfs)) ? y - PixW'(LumaOfs) : '0;
    return signed'(SumW'({yo, {FracW{1'b0}}}));
  endfunction

  // floor divide by 64, add offset back, clamp to a byte
  function automatic logic [PixW-1:0] scale_clamp(logic signed [SumW-1:0] s,
                                                  logic [PixW:0] ofs);
    logic signed [SumW-1:0] v;
    v = (s >>> FracW) + signed'(SumW'(ofs));
    if (v < 0) begin
      return '0;
    end else if (v > signed'(SumW'(PixMax))) begin
      return PixW'(PixMax);
    end else begin
      return v[PixW-1:0];
    end
  endfunction

  always_comb begin
    coef    = coef_lookup(mode_q);
    cbd     = signed'(SumW'(s1_req_q.chroma_blue)) - signed'(SumW'(ChromaOfs));
    crd     = signed'(SumW'(s1_req_q.chroma_red)) - signed'(SumW'(ChromaOfs));
    cross_y = cbd * SumW'(coef.kyb) + crd * SumW'(coef.kyr);
    sum_y0  = luma_base(s1_req_q.luma_first) + cross_y;
    sum_y1  = luma_base(s1_req_q.luma_second) + cross_y;
    sum_cb  = cbd * SumW'(coef.kbb) + crd * SumW'(coef.kbr);
    sum_cr  = cbd * SumW'(coef.krb) + crd * SumW'(coef.krr);
    out_rsp_d.new_luma_first  = scale_clamp(sum_y0, (PixW+1)'(LumaOfs));
    out_rsp_d.new_chroma_blue = scale_clamp(sum_cb, (PixW+1)'(ChromaOfs));
    out_rsp_d.new_luma_second = scale_clamp(sum_y1, (PixW+1)'(LumaOfs));
    out_rsp_d.new_chroma_red  = scale_clamp(sum_cr, (PixW+1)'(ChromaOfs));
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // an accepted request always lands in the input register
  `YCM_ASSERT_NEXT(a_in_capture, in_valid_i && in_ready_o, s1_valid_q,
                   "accepted request not captured")
  // a request that moves forward always shows up as a result
  `YCM_ASSERT_NEXT(a_s1_to_out, s1_adv, out_valid_q, "request lost between stages")
  // back pressure only when both registers are full and the result is stalled
  `YCM_ASSERT_NOW(a_ready_low, !in_ready_o, s1_valid_q && out_valid_q && !out_ready_i,
                  "input stalled without full pipeline")

endmodule

@@ test/tb.sv @@
module tb;
  import ycm_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseItems = 144;

  typedef struct {
    bit          is_cfg;
    ycm_req_t    px;
    mode_e       m;
    int unsigned in_pct;
    int unsigned out_pct;
  } job_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready_o;
  logic [1:0] cfg_data = 2'd0;
  logic     in_valid = 1'b0;
  logic     in_ready_o;
  ycm_req_t in_req = '0;
  logic     out_valid_o;
  logic     out_ready = 1'b0;
  ycm_rsp_t out_rsp_o;

  job_t        jobs[$];
  ycm_rsp_t    expected_px[$];
  mode_e       cur_mode = MODE_709_TO_601;
  int unsigned in_pct = 25;
  int unsigned out_pct = 25;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  int unsigned fails = 0;
  int unsigned cycles = 0;

  ycbcr_colorimetry_matrix dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [7:0] clamp_pixel(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // luma drops its 16 offset (floored at zero), adds the chroma cross terms
  function automatic logic [7:0] luma_term(logic [7:0] y, int cbd, int crd, int kb, int kr);
    int yo;
    int s;
    yo = (int'(y) > 16) ? int'(y) - 16 : 0;
    s = yo * 64 + cbd * kb + crd * kr;
    return clamp_pixel((s >>> 6) + 16);
  endfunction

  function automatic ycm_rsp_t convert_macropixel(ycm_req_t px, mode_e m);
    int kyb, kyr, kbb, kbr, krb, krr;
    int cbd, crd;
    ycm_rsp_t r;
    case (m)
      MODE_709_TO_601: begin
        kyb = 6;  kyr = 12;  kbb = 63; kbr = -7; krb = -5; krr = 62;
      end
      MODE_601_TO_709: begin
        kyb = -7; kyr = -13; kbb = 65; kbr = 7;  krb = 5;  krr = 66;
      end
      default: begin
        kyb = 0;  kyr = 0;   kbb = 64; kbr = 0;  krb = 0;  krr = 64;
      end
    endcase
    cbd = int'(px.chroma_blue) - 128;
    crd = int'(px.chroma_red) - 128;
    r.new_luma_first  = luma_term(px.luma_first, cbd, crd, kyb, kyr);
    r.new_chroma_blue = clamp_pixel(((cbd * kbb + crd * kbr) >>> 6) + 128);
    r.new_luma_second = luma_term(px.luma_second, cbd, crd, kyb, kyr);
    r.new_chroma_red  = clamp_pixel(((cbd * krb + crd * krr) >>> 6) + 128);
    return r;
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] corners[10];
    corners = '{8'd0, 8'd1, 8'd15, 8'd16, 8'd17, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
    if ($urandom_range(99) < 30) return corners[$urandom_range(9)];
    return 8'($urandom);
  endfunction

  task automatic add_pixel(logic [7:0] y0, logic [7:0] cb, logic [7:0] y1, logic [7:0] cr);
    job_t j;
    j = '{is_cfg: 1'b0, px: '0, m: MODE_709_TO_601, in_pct: 0, out_pct: 0};
    j.px = '{luma_first: y0, chroma_blue: cb, luma_second: y1, chroma_red: cr};
    jobs.push_back(j);
  endtask

  task automatic add_mode(mode_e m, int unsigned ip, int unsigned op);
    job_t j;
    j = '{is_cfg: 1'b1, px: '0, m: m, in_pct: ip, out_pct: op};
    jobs.push_back(j);
  endtask

  // request side: a mode write waits until every result has come back
  always @(posedge clk_i or negedge rst_ni) begin
    logic nxt_in_valid;
    logic nxt_cfg_valid;
    logic in_done;
    logic cfg_done;
    job_t j;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      in_done = in_valid && in_ready_o;
      cfg_done = cfg_valid && cfg_ready_o;
      if (in_done) expected_px.push_back(convert_macropixel(in_req, cur_mode));
      if (cfg_done) cur_mode = mode_e'(cfg_data);
      nxt_in_valid = in_valid && !in_done;
      nxt_cfg_valid = cfg_valid && !cfg_done;
      if (!nxt_in_valid && !nxt_cfg_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (jobs.size() > 0) begin
          if (!jobs[0].is_cfg) begin
            j = jobs.pop_front();
            in_req <= j.px;
            nxt_in_valid = 1'b1;
            if ($urandom_range(99) < in_pct) in_gap = $urandom_range(1, 7);
          end else if (expected_px.size() == 0) begin
            j = jobs.pop_front();
            cfg_data <= j.m;
            nxt_cfg_valid = 1'b1;
            in_pct = j.in_pct;
            out_pct = j.out_pct;
          end
        end
      end
      in_valid <= nxt_in_valid;
      cfg_valid <= nxt_cfg_valid;
    end
  end

  // result side: check against oldest expectation, stall in bursts
  always @(posedge clk_i or negedge rst_ni) begin
    ycm_rsp_t want;
    string names[4];
    names = '{"new_luma_first", "new_chroma_blue", "new_luma_second", "new_chroma_red"};
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (expected_px.size() == 0) begin
          $display("%0t: result with nothing expected, got %h", $time, out_rsp_o);
          fails++;
        end else begin
          want = expected_px.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (want[31-8*i -: 8] !== out_rsp_o[31-8*i -: 8]) begin
              $display("%0t: %s expected %0d actual %0d", $time, names[i],
                       want[31-8*i -: 8], out_rsp_o[31-8*i -: 8]);
              fails++;
            end
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else if ($urandom_range(99) < out_pct) begin
        out_stall = $urandom_range(1, 7) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int unsigned pcts[3];
    mode_e m;
    pcts = '{0, 15, 40};

    // extremes, luma around the 16 floor, neutral and saturated chroma, per mode
    for (int k = 0; k < 4; k++) begin
      if (k > 0) add_mode(mode_e'(k), 25, 25);
      add_pixel(8'd0, 8'd0, 8'd0, 8'd0);
      add_pixel(8'd255, 8'd255, 8'd255, 8'd255);
      add_pixel(8'd15, 8'd128, 8'd16, 8'd128);
      add_pixel(8'd17, 8'd0, 8'd235, 8'd255);
      add_pixel(8'd255, 8'd255, 8'd0, 8'd0);
      add_pixel(8'd0, 8'd0, 8'd255, 8'd255);
    end

    for (int ph = 0; ph < 8; ph++) begin
      m = (ph < 4) ? mode_e'(3 - ph) : mode_e'($urandom_range(0, 3));
      if (ph == 7) add_mode(m, 0, 0);
      else add_mode(m, pcts[$urandom_range(2)], pcts[$urandom_range(2)]);
      for (int n = 0; n < PhaseItems; n++) begin
        add_pixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (jobs.size() != 0 || in_valid || cfg_valid || expected_px.size() != 0);
    repeat (8) @(posedge clk_i);

    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
